@@ rtl/sscu_pkg.sv @@
// ----------------------------------------------------------------------------
// sscu_pkg
// widths, sideband type and helpers shared by the sphere collision pipeline
// ----------------------------------------------------------------------------
package sscu_pkg;

   localparam int CoordW = 31;
   localparam int RadW   = 30;
   localparam int DiffW  = 32;
   localparam int SqW    = 64;
   localparam int RsqW   = 62;
   localparam int RootW  = 32;
   localparam int NumW   = 62;
   localparam int QuotW  = 30;
   localparam int FarW   = 32;
   localparam int NormW  = 18;
   localparam int DepthW = 31;
   localparam int NormShift = 16;

   typedef struct packed {
      logic [2:0][CoordW-1:0] ca;
      logic [2:0][CoordW-1:0] cb;
      logic [2:0]             neg;
      logic [2:0][DiffW-1:0]  ad;
      logic [RadW-1:0]        ra;
      logic [RadW-1:0]        rb;
      logic [RadW:0]          rsum;
      logic                   hit;
      logic                   coinc;
      logic [RootW-1:0]       dlen;
   } side_type;

   function automatic logic [FarW-1:0] sat_far(input logic signed [FarW:0] v);
      logic [FarW-1:0] r;
      if (v > $signed({2'b00, {(FarW-1){1'b1}}})) begin
         r = {1'b0, {(FarW-1){1'b1}}};
      end else if (v < $signed({2'b11, {(FarW-1){1'b0}}})) begin
         r = {1'b1, {(FarW-1){1'b0}}};
      end else begin
         r = v[FarW-1:0];
      end
      return r;
   endfunction

   function automatic logic [NormW-1:0] clamp_norm(input logic signed [QuotW:0] v);
      logic [NormW-1:0] r;
      if (v > $signed((QuotW+1)'(1 << NormShift))) begin
         r = NormW'(1 << NormShift);
      end else if (v < -$signed((QuotW+1)'(1 << NormShift))) begin
         r = -NormW'(1 << NormShift);
      end else begin
         r = v[NormW-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/sscu_isqrt.sv @@
// ----------------------------------------------------------------------------
// sscu_isqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module sscu_isqrt #(
   parameter int ROOT_W = sscu_pkg::RootW
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic [ROOT_W-1:0]   root
);

   localparam int InW = 2 * ROOT_W;

   logic [ROOT_W+1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [InW-1:0]    rad_ff  [ROOT_W];

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_step
      logic [ROOT_W+1:0] rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [InW-1:0]    rad_src;
      logic [ROOT_W+1:0] shifted;
      logic [ROOT_W+1:0] trial;
      logic              fit;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      assign shifted = {rem_src[ROOT_W-1:0], rad_src[InW-1 -: 2]};
      assign trial   = {root_src, 2'b01};
      assign fit     = shifted >= trial;

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= fit ? shifted - trial : shifted;
            root_ff[k] <= {root_src[ROOT_W-2:0], fit};
            rad_ff[k]  <= rad_src << 2;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

@@ rtl/sscu_div.sv @@
// ----------------------------------------------------------------------------
// sscu_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module sscu_div #(
   parameter int NUM_W  = sscu_pkg::NumW,
   parameter int QUOT_W = sscu_pkg::QuotW,
   parameter int DEN_W  = sscu_pkg::RootW
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [QUOT_W-1:0] quot
);

   logic [DEN_W-1:0]  rem_ff [QUOT_W];
   logic [QUOT_W-1:0] lo_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_ff [QUOT_W];
   logic [QUOT_W-1:0] quo_ff [QUOT_W];

   genvar k;
   for (k = 0; k < QUOT_W; k++) begin : g_step
      logic [DEN_W-1:0]  rem_src;
      logic [DEN_W-1:0]  den_src;
      logic [QUOT_W-1:0] lo_src;
      logic [QUOT_W-1:0] quo_src;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              fit;

      if (k == 0) begin : g_first
         assign rem_src = DEN_W'(num >> QUOT_W);
         assign lo_src  = num[QUOT_W-1:0];
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign lo_src  = lo_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      assign trial = {rem_src, lo_src[QUOT_W-1]};
      assign diff  = trial - {1'b0, den_src};
      assign fit   = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lo_ff[k]  <= lo_src << 1;
            den_ff[k] <= den_src;
            quo_ff[k] <= {quo_src[QUOT_W-2:0], fit};
         end
      end
   end

   assign quot = quo_ff[QUOT_W-1];

endmodule

@@ rtl/sphere_sphere_collision_unit.sv @@
// ----------------------------------------------------------------------------
// sphere_sphere_collision_unit
// throughput: one item per cycle, set by the one-bit-per-stage root and divide
// pipes; a stalled result holds the whole pipe
// reset: synchronous, clears the valid bits only; the pipe is empty after it
// ----------------------------------------------------------------------------
module sphere_sphere_collision_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_center_a_x,
   input  logic [30:0] req_center_a_y,
   input  logic [30:0] req_center_a_z,
   input  logic [29:0] req_radius_a,
   input  logic [30:0] req_center_b_x,
   input  logic [30:0] req_center_b_y,
   input  logic [30:0] req_center_b_z,
   input  logic [29:0] req_radius_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_coincident,
   output logic [31:0] rsp_far_a_x,
   output logic [31:0] rsp_far_a_y,
   output logic [31:0] rsp_far_a_z,
   output logic [31:0] rsp_far_b_x,
   output logic [31:0] rsp_far_b_y,
   output logic [31:0] rsp_far_b_z,
   output logic [17:0] rsp_normal_x,
   output logic [17:0] rsp_normal_y,
   output logic [17:0] rsp_normal_z,
   output logic [30:0] rsp_depth
);

   localparam int CoordW = sscu_pkg::CoordW;
   localparam int DiffW  = sscu_pkg::DiffW;
   localparam int SqW    = sscu_pkg::SqW;
   localparam int RsqW   = sscu_pkg::RsqW;
   localparam int RootW  = sscu_pkg::RootW;
   localparam int NumW   = sscu_pkg::NumW;
   localparam int QuotW  = sscu_pkg::QuotW;
   localparam int FarW   = sscu_pkg::FarW;
   localparam int NormW  = sscu_pkg::NormW;
   localparam int DepthW = sscu_pkg::DepthW;

   logic en;

   sscu_pkg::side_type side1_in, side1_ff, side2_ff, side3_in, side3_ff;
   sscu_pkg::side_type side4_in, side4_ff;
   sscu_pkg::side_type sq_side_ff  [RootW];
   sscu_pkg::side_type div_side_ff [QuotW];
   logic               vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic               sq_vld_ff  [RootW];
   logic               div_vld_ff [QuotW];

   logic [2:0][SqW-1:0]  sq_ff;
   logic [RsqW-1:0]      rsq_ff;
   logic [SqW-1:0]       sum_in, sum_ff;
   logic [RootW-1:0]     root;
   logic [2:0][NumW-1:0] pa_ff, pb_ff, pn_ff;
   logic [2:0][QuotW-1:0] qa, qb, qn;

   logic [2:0][FarW-1:0]  far_a_in, far_b_in;
   logic [2:0][NormW-1:0] norm_in;
   logic [DepthW-1:0]     depth_in;
   logic                  hit_in, coinc_in;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: differences and magnitudes
   always_comb begin
      logic signed [DiffW-1:0] dif;
      side1_in      = '0;
      side1_in.ca   = {req_center_a_z, req_center_a_y, req_center_a_x};
      side1_in.cb   = {req_center_b_z, req_center_b_y, req_center_b_x};
      side1_in.ra   = req_radius_a;
      side1_in.rb   = req_radius_b;
      side1_in.rsum = {1'b0, req_radius_a} + {1'b0, req_radius_b};
      for (int i = 0; i < 3; i++) begin
         dif = $signed({side1_in.cb[i][CoordW-1], side1_in.cb[i]})
             - $signed({side1_in.ca[i][CoordW-1], side1_in.ca[i]});
         side1_in.neg[i] = dif[DiffW-1];
         side1_in.ad[i]  = dif[DiffW-1] ? DiffW'(-dif) : DiffW'(dif);
      end
   end

   // stage 3: squared distance and hit test
   always_comb begin
      sum_in         = sq_ff[0] + sq_ff[1] + sq_ff[2];
      side3_in       = side2_ff;
      side3_in.hit   = sum_in <= {{(SqW-RsqW){1'b0}}, rsq_ff};
      side3_in.coinc = sum_in == '0;
   end

   always_comb begin
      side4_in      = sq_side_ff[RootW-1];
      side4_in.dlen = root;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SqW'(side1_ff.ad[i]) * SqW'(side1_ff.ad[i]);
         end
         rsq_ff   <= RsqW'(side1_ff.rsum) * RsqW'(side1_ff.rsum);
         side3_ff <= side3_in;
         sum_ff   <= sum_in;
         sq_side_ff[0] <= side3_ff;
         for (int k = 1; k < RootW; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end
         side4_ff <= side4_in;
         for (int i = 0; i < 3; i++) begin
            pa_ff[i] <= NumW'(sq_side_ff[RootW-1].ra) * NumW'(sq_side_ff[RootW-1].ad[i]);
            pb_ff[i] <= NumW'(sq_side_ff[RootW-1].rb) * NumW'(sq_side_ff[RootW-1].ad[i]);
            pn_ff[i] <= NumW'(sq_side_ff[RootW-1].ad[i]) << sscu_pkg::NormShift;
         end
         div_side_ff[0] <= side4_ff;
         for (int k = 1; k < QuotW; k++) begin
            div_side_ff[k] <= div_side_ff[k-1];
         end
         rsp_hit        <= hit_in;
         rsp_coincident <= coinc_in;
         rsp_far_a_x    <= far_a_in[0];
         rsp_far_a_y    <= far_a_in[1];
         rsp_far_a_z    <= far_a_in[2];
         rsp_far_b_x    <= far_b_in[0];
         rsp_far_b_y    <= far_b_in[1];
         rsp_far_b_z    <= far_b_in[2];
         rsp_normal_x   <= norm_in[0];
         rsp_normal_y   <= norm_in[1];
         rsp_normal_z   <= norm_in[2];
         rsp_depth      <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff   <= 1'b0;
         vld2_ff   <= 1'b0;
         vld3_ff   <= 1'b0;
         vld4_ff   <= 1'b0;
         rsp_valid <= 1'b0;
         for (int k = 0; k < RootW; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
         for (int k = 0; k < QuotW; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld1_ff      <= req_valid;
         vld2_ff      <= vld1_ff;
         vld3_ff      <= vld2_ff;
         sq_vld_ff[0] <= vld3_ff;
         for (int k = 1; k < RootW; k++) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
         vld4_ff       <= sq_vld_ff[RootW-1];
         div_vld_ff[0] <= vld4_ff;
         for (int k = 1; k < QuotW; k++) begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
         rsp_valid <= div_vld_ff[QuotW-1];
      end
   end

   sscu_isqrt #(
      .ROOT_W (RootW)
   ) u_isqrt (
      .clock    (clock),
      .enable   (en),
      .radicand (sum_ff),
      .root     (root)
   );

   genvar g;
   for (g = 0; g < 3; g++) begin : g_axis
      sscu_div #(.NUM_W(NumW), .QUOT_W(QuotW), .DEN_W(RootW)) u_div_a (
         .clock (clock), .enable (en), .num (pa_ff[g]), .den (side4_ff.dlen), .quot (qa[g])
      );
      sscu_div #(.NUM_W(NumW), .QUOT_W(QuotW), .DEN_W(RootW)) u_div_b (
         .clock (clock), .enable (en), .num (pb_ff[g]), .den (side4_ff.dlen), .quot (qb[g])
      );
      sscu_div #(.NUM_W(NumW), .QUOT_W(QuotW), .DEN_W(RootW)) u_div_n (
         .clock (clock), .enable (en), .num (pn_ff[g]), .den (side4_ff.dlen), .quot (qn[g])
      );
   end

   // output stage: signs, saturation, miss and coincident cases
   always_comb begin
      sscu_pkg::side_type     sd;
      logic signed [QuotW:0]  off_a, off_b, nq;
      logic signed [FarW:0]   fa, fb;
      sd       = div_side_ff[QuotW-1];
      off_a    = '0;
      off_b    = '0;
      nq       = '0;
      fa       = '0;
      fb       = '0;
      far_a_in = '0;
      far_b_in = '0;
      norm_in  = '0;
      depth_in = '0;
      hit_in   = sd.hit;
      coinc_in = sd.hit && sd.coinc;
      if (sd.hit && sd.coinc) begin
         depth_in = DepthW'(sd.rsum);
         for (int i = 0; i < 3; i++) begin
            far_a_in[i] = {sd.ca[i][CoordW-1], sd.ca[i]};
            far_b_in[i] = {sd.cb[i][CoordW-1], sd.cb[i]};
         end
      end else if (sd.hit) begin
         depth_in = DepthW'(sd.rsum) - DepthW'(sd.dlen);
         for (int i = 0; i < 3; i++) begin
            off_a = sd.neg[i] ? -$signed({1'b0, qa[i]}) : $signed({1'b0, qa[i]});
            off_b = sd.neg[i] ? -$signed({1'b0, qb[i]}) : $signed({1'b0, qb[i]});
            nq    = sd.neg[i] ? -$signed({1'b0, qn[i]}) : $signed({1'b0, qn[i]});
            fa = $signed({{2{sd.ca[i][CoordW-1]}}, sd.ca[i]})
               - $signed({{(FarW-QuotW){off_a[QuotW]}}, off_a});
            fb = $signed({{2{sd.cb[i][CoordW-1]}}, sd.cb[i]})
               + $signed({{(FarW-QuotW){off_b[QuotW]}}, off_b});
            far_a_in[i] = sscu_pkg::sat_far(fa);
            far_b_in[i] = sscu_pkg::sat_far(fb);
            norm_in[i]  = sscu_pkg::clamp_norm(nq);
         end
      end
   end

endmodule

@@ rtl/sscu_checker.sv @@
// ----------------------------------------------------------------------------
// sscu_checker
// port-level checks on the collision result channel
// ----------------------------------------------------------------------------
module sscu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit,
   input logic        rsp_coincident,
   input logic [31:0] rsp_far_a_x,
   input logic [17:0] rsp_normal_x,
   input logic [17:0] rsp_normal_y,
   input logic [17:0] rsp_normal_z,
   input logic [30:0] rsp_depth
);

   a_coinc_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |-> rsp_hit)
      else $error("coincident without hit");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_depth == '0 && rsp_far_a_x == '0 && rsp_normal_x == '0)
      else $error("miss result not zero");

   a_coinc_norm : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_coincident |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("coincident normal not zero");

   a_norm_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_normal_x) <= 18'sd65536 && $signed(rsp_normal_x) >= -18'sd65536)
      else $error("normal out of range");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_depth))
      else $error("stalled item changed");

endmodule

bind sphere_sphere_collision_unit sscu_checker u_sscu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_coincident (rsp_coincident),
   .rsp_far_a_x    (rsp_far_a_x),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y),
   .rsp_normal_z   (rsp_normal_z),
   .rsp_depth      (rsp_depth)
);
